FILE: rtl/core/lsws_pkg.sv
// Shared types, request and status codes, and defaults for the search stack.
package lsws_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int WORD_W_DEF  = 32;

  localparam int REQ_W       = 3;
  localparam int IO_W        = 32;
  localparam int STATUS_W    = 2;
  localparam int POS_OUT_W   = 6;
  localparam int FILL_OUT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic {
    FSM_IDLE,
    FSM_WALK
  } fsm_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     tail;
  } cell_ctl_t;

endpackage

FILE: rtl/core/lsws_req_if.sv
// Request channel: valid/ready handshake with the request code and word.
interface lsws_req_if;
  logic                                valid;
  logic                                ready;
  logic [lsws_pkg::REQ_W-1:0]          req_type;
  logic signed [lsws_pkg::IO_W-1:0]    value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

FILE: rtl/core/lsws_rsp_if.sv
// Response channel: valid/ready handshake with status, word, position and fill.
interface lsws_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [lsws_pkg::STATUS_W-1:0]       status;
  logic signed [lsws_pkg::IO_W-1:0]    data;
  logic [lsws_pkg::POS_OUT_W-1:0]      position;
  logic [lsws_pkg::FILL_OUT_W-1:0]     fill_count;
  logic                                last;

  modport source (output valid, output status, output data, output position,
                  output fill_count, output last, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input fill_count, input last, output ready);
endinterface

FILE: rtl/core/lsws_cell.sv
// One stack cell: holds a word and trades it with its neighbors on push, pop and rotate.
module lsws_cell #(
  parameter int WORD_WIDTH = lsws_pkg::WORD_W_DEF
) (
  input  logic                  clk,
  input  lsws_pkg::cell_ctl_t   ctl,
  input  logic [WORD_WIDTH-1:0] from_up,
  input  logic [WORD_WIDTH-1:0] from_down,
  input  logic [WORD_WIDTH-1:0] top_word,
  output logic [WORD_WIDTH-1:0] word
);
  import lsws_pkg::*;

  // Contents are undefined until written, so the word carries no reset.
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_PUSH: word <= from_up;
      CELL_POP:  word <= from_down;
      CELL_ROT:  word <= ctl.tail ? top_word : from_down;
      default:   word <= word;
    endcase
  end

endmodule

FILE: rtl/core/lifo_stack_with_search.sv
// Top level: a LIFO stack built as a chain of cells, with dump and search by rotation.
// Push, pop, peek, clear and requests on an empty stack: the result is registered and
// shown in the cycle after the accept. Dump and search rotate the chain once, one cell
// per cycle while the response register has room; no request is taken until they end.
// Dump emits one response per rotation step; search emits its single response on the last step.
// Synchronous reset empties the stack and drops any pending response.
module lifo_stack_with_search #(
  parameter int DEPTH      = lsws_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = lsws_pkg::WORD_W_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lsws_req_if.sink    req,
  lsws_rsp_if.source  rsp
);
  import lsws_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int POS_W  = $clog2(DEPTH);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  // The cells. Cell 0 is the top of the stack; cell fill-1 holds the oldest word.
  logic [WORD_WIDTH-1:0] cell_word [DEPTH];
  cell_ctl_t             cell_ctl  [DEPTH];

  // Control registers.
  fsm_state_t            state, state_next;
  logic [FILL_W-1:0]     fill, fill_next;
  logic [POS_W-1:0]      cnt;
  logic                  walk_dump;
  logic                  found;
  logic [POS_W-1:0]      found_pos;
  logic [WORD_WIDTH-1:0] key;

  // Output register.
  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic signed [IO_W-1:0]    out_data;
  logic [POS_OUT_W-1:0]      out_pos;
  logic [FILL_OUT_W-1:0]     out_fill;
  logic                      out_last;

  logic                      load_out;
  logic [STATUS_W-1:0]       out_status_next;
  logic signed [IO_W-1:0]    out_data_next;
  logic [POS_OUT_W-1:0]      out_pos_next;
  logic                      out_last_next;

  logic                  out_free;
  logic                  req_fire;
  logic                  walk_step;
  logic                  walk_end;
  logic                  is_empty;
  logic                  is_full;
  logic                  top_match;
  logic [FILL_W-1:0]     fill_m1;
  logic [WORD_WIDTH-1:0] top_word;
  logic [WORD_WIDTH-1:0] new_word;
  logic signed [IO_W-1:0] top_io;
  cell_op_t              chain_op;

  // The response register can take a new response when it is empty or being drained.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == FSM_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;

  assign is_empty  = (fill == '0);
  assign is_full   = (fill == FULL_FILL);
  assign fill_m1   = fill - FILL_W'(1);
  assign top_word  = cell_word[0];

  // Signed size casts sign-extend or cut the word at the channel boundary.
  assign new_word  = WORD_WIDTH'(req.value);
  assign top_io    = IO_W'(signed'(top_word));
  assign top_match = (top_word == key);

  // A rotation step advances only when the response register has room, so a
  // stalled dump never loses a word and the chain stays in step with cnt.
  assign walk_step = (state == FSM_WALK) && out_free;
  assign walk_end  = walk_step && (FILL_W'(cnt) == fill_m1);

  // One operation drives the whole chain; each cell adds its own neighbors.
  always_comb begin
    chain_op = CELL_HOLD;
    if (req_fire) begin
      if ((req.req_type == REQ_PUSH) && !is_full) begin
        chain_op = CELL_PUSH;
      end else if ((req.req_type == REQ_POP) && !is_empty) begin
        chain_op = CELL_POP;
      end
    end else if (walk_step) begin
      chain_op = CELL_ROT;
    end
  end

  // During a rotation the old top wraps around into the deepest occupied cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] up_word;
    logic [WORD_WIDTH-1:0] down_word;

    if (i == 0) begin : g_up_top
      assign up_word = new_word;
    end else begin : g_up_mid
      assign up_word = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_down_bot
      assign down_word = cell_word[i];
    end else begin : g_down_mid
      assign down_word = cell_word[i+1];
    end

    assign cell_ctl[i].op   = chain_op;
    assign cell_ctl[i].tail = (fill_m1 == FILL_W'(i));

    lsws_cell #(
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .from_up   (up_word),
      .from_down (down_word),
      .top_word  (top_word),
      .word      (cell_word[i])
    );
  end

  // Fill count follows pushes, pops and clears; walks leave it alone.
  always_comb begin
    fill_next = fill;
    if (chain_op == CELL_PUSH) begin
      fill_next = fill + FILL_W'(1);
    end else if (chain_op == CELL_POP) begin
      fill_next = fill_m1;
    end else if (req_fire && (req.req_type == REQ_CLEAR)) begin
      fill_next = '0;
    end
  end

  // Next state: a dump or search of a non-empty stack starts a rotation.
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (req_fire && !is_empty &&
            ((req.req_type == REQ_DUMP) || (req.req_type == REQ_SEARCH))) begin
          state_next = FSM_WALK;
        end
      end
      FSM_WALK: begin
        if (walk_end) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // Response contents. Every response is a single final one except dump steps.
  always_comb begin
    load_out        = 1'b0;
    out_status_next = ST_OK;
    out_data_next   = '0;
    out_pos_next    = '0;
    out_last_next   = 1'b1;
    case (state)
      FSM_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_PUSH: begin
              load_out        = 1'b1;
              out_status_next = is_full ? ST_FULL : ST_OK;
            end
            REQ_POP, REQ_PEEK: begin
              load_out = 1'b1;
              if (is_empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                out_data_next = top_io;
              end
            end
            REQ_DUMP, REQ_SEARCH: begin
              // Non-empty cases respond from the rotation instead.
              load_out        = is_empty;
              out_status_next = ST_EMPTY;
            end
            REQ_CLEAR: begin
              load_out = 1'b1;
            end
            default: begin
              // Unused request codes are taken and produce no response.
              load_out = 1'b0;
            end
          endcase
        end
      end
      FSM_WALK: begin
        if (walk_dump) begin
          load_out      = walk_step;
          out_data_next = top_io;
          out_pos_next  = POS_OUT_W'(cnt);
          out_last_next = walk_end;
        end else begin
          load_out = walk_end;
          if (found) begin
            out_pos_next = POS_OUT_W'(found_pos);
          end else if (top_match) begin
            out_pos_next = POS_OUT_W'(cnt);
          end else begin
            out_status_next = ST_NOT_FOUND;
          end
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      fill      <= '0;
      cnt       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (req_fire) begin
        cnt   <= '0;
        found <= 1'b0;
      end else if (walk_step) begin
        cnt <= cnt + POS_W'(1);
        if (!found && top_match) begin
          found <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      key       <= new_word;
      walk_dump <= (req.req_type == REQ_DUMP);
    end
    if (walk_step && !found && top_match) begin
      found_pos <= cnt;
    end
    if (load_out) begin
      out_status <= out_status_next;
      out_data   <= out_data_next;
      out_pos    <= out_pos_next;
      out_fill   <= FILL_OUT_W'(fill_next);
      out_last   <= out_last_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.data       = out_data;
  assign rsp.position   = out_pos;
  assign rsp.fill_count = out_fill;
  assign rsp.last       = out_last;

  // The fill count never runs past the capacity of the chain.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_FILL)
    else $error("fill count beyond capacity");

  // A rotation never changes how many words are held.
  a_walk_fill: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_WALK) |=> (fill == $past(fill)))
    else $error("fill changed during a rotation");

  // The rotation step counter stays inside the occupied cells.
  a_walk_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_WALK) |-> (FILL_W'(cnt) < fill))
    else $error("rotation counter beyond fill");

  // A rotation only runs on a non-empty stack.
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_WALK) |-> !is_empty)
    else $error("rotation on an empty stack");

endmodule
